FILE: src/gpp_pkg.sv
`timescale 1ns / 1ps

package gpp_pkg;

   // Item kinds (travel on req_tuser)
   localparam logic [2:0] MODE_READ     = 3'd0;
   localparam logic [2:0] MODE_WRITE    = 3'd1;
   localparam logic [2:0] MODE_PIN_CHG  = 3'd2;
   localparam logic [2:0] MODE_PIN_KIND = 3'd3;
   localparam logic [2:0] MODE_PIN_IRQ  = 3'd4;

   // Register map
   localparam logic [3:0] REG_OUT      = 4'd0;
   localparam logic [3:0] REG_SET      = 4'd1;
   localparam logic [3:0] REG_CLR      = 4'd2;
   localparam logic [3:0] REG_IN       = 4'd3;
   localparam logic [3:0] REG_DIR      = 4'd4;
   localparam logic [3:0] REG_INT_EN   = 4'd5;
   localparam logic [3:0] REG_INT_TYPE = 4'd6;
   localparam logic [3:0] REG_INT_STAT = 4'd7;
   localparam logic [3:0] REG_INT_CLR  = 4'd8;
   localparam logic [3:0] REG_PULLUP   = 4'd9;
   localparam logic [3:0] REG_PULLDOWN = 4'd10;

   // Pin modes
   localparam logic [2:0] KIND_IN     = 3'd0;
   localparam logic [2:0] KIND_OUT    = 3'd1;
   localparam logic [2:0] KIND_IN_PU  = 3'd2;
   localparam logic [2:0] KIND_IN_PD  = 3'd3;
   localparam logic [2:0] KIND_OD     = 3'd4;
   localparam logic [2:0] KIND_ANALOG = 3'd5;
   localparam logic [2:0] KIND_PWM    = 3'd6;

   // Pin interrupt modes
   localparam logic [2:0] IRQ_NONE = 3'd0;
   localparam logic [2:0] IRQ_RISE = 3'd1;
   localparam logic [2:0] IRQ_FALL = 3'd2;
   localparam logic [2:0] IRQ_BOTH = 3'd3;
   localparam logic [2:0] IRQ_LOW  = 3'd4;
   localparam logic [2:0] IRQ_HIGH = 3'd5;

   localparam int REG_WIDTH = 32;

   // Per-pin update command, already qualified by the commit strobe
   typedef struct packed {
      logic       drive;
      logic       level_val;
      logic       set_kind;
      logic [2:0] kind_val;
      logic       set_irq_kind;
      logic [2:0] irq_kind_val;
      logic       dir_write;
      logic       dir_val;
      logic       en_write;
      logic       en_val;
   } pin_cmd_type;

   typedef struct packed {
      logic level_next;
      logic fire;
      logic input_bit;
   } pin_stat_type;

   function automatic logic is_output_kind(input logic [2:0] k);
      return (k == KIND_OUT) || (k == KIND_OD) || (k == KIND_PWM);
   endfunction

endpackage

FILE: src/gpio_port_with_pin_interrupts_unit.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// req       in   req_tvalid/tready  tuser: mode; tdata: reg_index .. pin_setting
// rsp       out  rsp_tvalid/tready  tdata: read_data .. pad_direction
//
// One transaction per cycle sustained while rsp is not stalled; a taken request
// passes the input register, then the result register, before it shows up on rsp.
// All register and pin updates happen as the request leaves the input register.
// Reset is synchronous and clears the valid flags, port registers, pin modes and
// interrupt modes, not the payload registers. A stalled rsp holds its result;
// req stays ready while the input register can move on.

module gpio_port_with_pin_interrupts_unit #(
   parameter int PIN_COUNT = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,   // [2:0] mode
   // [3:0] reg_index, [35:4] write_data, [41:36] pin, [42] level,
   // [45:43] pin_setting, [47:46] zero
   input  logic [47:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] read_data, [32] error, [64:33] irq_status, [96:65] pad_levels,
   // [128:97] pad_direction, [135:129] zero
   output logic [135:0] rsp_tdata
);
   import gpp_pkg::*;

   localparam logic [REG_WIDTH-1:0] PIN_MASK =
      REG_WIDTH'((64'd1 << PIN_COUNT) - 64'd1);

   // input register
   logic        s1_valid_ff;
   logic [2:0]  mode_ff;
   logic [3:0]  reg_index_ff;
   logic [31:0] write_data_ff;
   logic [5:0]  pin_ff;
   logic        level_ff;
   logic [2:0]  pin_setting_ff;

   // port state
   logic [31:0] out_ff, out_in;
   logic [31:0] dir_ff, dir_in;
   logic [31:0] int_en_ff, int_en_in;
   logic [31:0] int_type_ff, int_type_in;
   logic [31:0] int_stat_ff, int_stat_in;
   logic [31:0] pullup_ff, pullup_in;
   logic [31:0] pulldown_ff, pulldown_in;
   logic [31:0] levels_ff, levels_in;

   // result register
   logic         rsp_valid_ff;
   logic [135:0] rsp_data_ff;

   logic        advance;
   logic        commit;
   logic        ok;
   logic [31:0] read_data;
   logic        pin_ok;
   logic        drive_all;
   logic        wr_dir, wr_en, kind_ok, irq_ok;
   logic [31:0] input_word;
   logic [31:0] fires;
   logic [31:0] clr_mask;

   pin_stat_type pin_stat [REG_WIDTH];

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign commit     = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign pin_ok = {1'b0, pin_ff} < 7'(PIN_COUNT);

   always_comb begin
      ok          = 1'b0;
      read_data   = '0;
      out_in      = out_ff;
      drive_all   = 1'b0;
      wr_dir      = 1'b0;
      wr_en       = 1'b0;
      int_type_in = int_type_ff;
      pullup_in   = pullup_ff;
      pulldown_in = pulldown_ff;
      clr_mask    = '0;
      kind_ok     = 1'b0;
      irq_ok      = 1'b0;
      case (mode_ff)
         MODE_READ: begin
            ok = 1'b1;
            case (reg_index_ff)
               REG_OUT:      read_data = out_ff;
               REG_IN:       read_data = input_word;
               REG_DIR:      read_data = dir_ff;
               REG_INT_EN:   read_data = int_en_ff;
               REG_INT_TYPE: read_data = int_type_ff;
               REG_INT_STAT: read_data = int_stat_ff;
               REG_PULLUP:   read_data = pullup_ff;
               REG_PULLDOWN: read_data = pulldown_ff;
               default:      ok = 1'b0;
            endcase
         end
         MODE_WRITE: begin
            ok = 1'b1;
            case (reg_index_ff)
               REG_OUT: begin
                  out_in    = write_data_ff;
                  drive_all = 1'b1;
               end
               REG_SET: begin
                  out_in    = out_ff | write_data_ff;
                  drive_all = 1'b1;
               end
               REG_CLR: begin
                  out_in    = out_ff & ~write_data_ff;
                  drive_all = 1'b1;
               end
               REG_DIR:      wr_dir      = 1'b1;
               REG_INT_EN:   wr_en       = 1'b1;
               REG_INT_TYPE: int_type_in = write_data_ff;
               REG_INT_CLR:  clr_mask    = write_data_ff;
               REG_PULLUP:   pullup_in   = write_data_ff;
               REG_PULLDOWN: pulldown_in = write_data_ff;
               default:      ok = 1'b0;
            endcase
         end
         MODE_PIN_CHG:  ok = pin_ok;
         MODE_PIN_KIND: begin
            kind_ok = pin_ok && (pin_setting_ff <= KIND_PWM);
            ok      = kind_ok;
         end
         MODE_PIN_IRQ: begin
            irq_ok = pin_ok && (pin_setting_ff <= IRQ_HIGH);
            ok     = irq_ok;
         end
         default: ok = 1'b0;
      endcase
   end

   for (genvar i = 0; i < REG_WIDTH; i++) begin : g_pin
      if (i < PIN_COUNT) begin : g_live
         pin_cmd_type cmd;
         logic        sel;

         assign sel = pin_ff == 6'(i);

         always_comb begin
            cmd.drive        = commit && (drive_all || (mode_ff == MODE_PIN_CHG && sel));
            cmd.level_val    = drive_all ? out_in[i] : level_ff;
            cmd.set_kind     = commit && kind_ok && sel;
            cmd.kind_val     = pin_setting_ff;
            cmd.set_irq_kind = commit && irq_ok && sel;
            cmd.irq_kind_val = pin_setting_ff;
            cmd.dir_write    = commit && wr_dir;
            cmd.dir_val      = write_data_ff[i];
            cmd.en_write     = commit && wr_en;
            cmd.en_val       = write_data_ff[i];
         end

         gpp_pin u_pin (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .level_cur (levels_ff[i]),
            .pull_up   (pullup_ff[i]),
            .pull_down (pulldown_ff[i]),
            .stat      (pin_stat[i])
         );
      end else begin : g_dead
         assign pin_stat[i] = '{level_next: levels_ff[i], fire: 1'b0, input_bit: 1'b0};
      end
      assign levels_in[i]  = pin_stat[i].level_next;
      assign fires[i]      = pin_stat[i].fire;
      assign input_word[i] = pin_stat[i].input_bit;
   end

   always_comb begin
      int_stat_in = (int_stat_ff & ~clr_mask) | fires;

      dir_in = wr_dir ? write_data_ff : dir_ff;
      if (kind_ok) begin
         dir_in[pin_ff[4:0]] = is_output_kind(pin_setting_ff);
      end

      int_en_in = wr_en ? write_data_ff : int_en_ff;
      if (irq_ok) begin
         int_en_in[pin_ff[4:0]] = pin_setting_ff != IRQ_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         out_ff       <= '0;
         dir_ff       <= '0;
         int_en_ff    <= '0;
         int_type_ff  <= '0;
         int_stat_ff  <= '0;
         pullup_ff    <= '0;
         pulldown_ff  <= '0;
         levels_ff    <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (commit) begin
            out_ff      <= out_in;
            dir_ff      <= dir_in;
            int_en_ff   <= int_en_in;
            int_type_ff <= int_type_in;
            int_stat_ff <= int_stat_in;
            pullup_ff   <= pullup_in;
            pulldown_ff <= pulldown_in;
            levels_ff   <= levels_in & PIN_MASK;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         mode_ff        <= req_tuser;
         reg_index_ff   <= req_tdata[3:0];
         write_data_ff  <= req_tdata[35:4];
         pin_ff         <= req_tdata[41:36];
         level_ff       <= req_tdata[42];
         pin_setting_ff <= req_tdata[45:43];
      end
      if (commit) begin
         rsp_data_ff <= {7'd0, dir_in, levels_in & PIN_MASK, int_stat_in, !ok, read_data};
      end
   end

endmodule

FILE: src/gpp_pin.sv
`timescale 1ns / 1ps

module gpp_pin (
   input  logic                 clock,
   input  logic                 reset,
   input  gpp_pkg::pin_cmd_type cmd,
   input  logic                 level_cur,
   input  logic                 pull_up,
   input  logic                 pull_down,
   output gpp_pkg::pin_stat_type stat
);
   import gpp_pkg::*;

   logic [2:0] kind_ff, kind_in;
   logic [2:0] irq_kind_ff, irq_kind_in;
   logic       fire;

   always_comb begin
      kind_in = kind_ff;
      if (cmd.set_kind) begin
         kind_in = cmd.kind_val;
      end else if (cmd.dir_write) begin
         if (cmd.dir_val && (kind_ff == KIND_IN || kind_ff == KIND_IN_PU ||
                             kind_ff == KIND_IN_PD)) begin
            kind_in = KIND_OUT;
         end else if (!cmd.dir_val && is_output_kind(kind_ff)) begin
            kind_in = KIND_IN;
         end
      end
   end

   always_comb begin
      irq_kind_in = irq_kind_ff;
      if (cmd.set_irq_kind) begin
         irq_kind_in = cmd.irq_kind_val;
      end else if (cmd.en_write && !cmd.en_val) begin
         irq_kind_in = IRQ_NONE;
      end
   end

   always_comb begin
      case (irq_kind_ff)
         IRQ_RISE: fire = !level_cur && cmd.level_val;
         IRQ_FALL: fire = level_cur && !cmd.level_val;
         IRQ_BOTH: fire = level_cur != cmd.level_val;
         IRQ_LOW:  fire = !cmd.level_val;
         IRQ_HIGH: fire = cmd.level_val;
         default:  fire = 1'b0;
      endcase
   end

   always_comb begin
      stat.level_next = cmd.drive ? cmd.level_val : level_cur;
      stat.fire       = cmd.drive && fire;
      // pulls only resolve plain inputs
      stat.input_bit  = (kind_ff == KIND_IN) ? (pull_up || (!pull_down && level_cur))
                                             : level_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff     <= KIND_IN;
         irq_kind_ff <= IRQ_NONE;
      end else begin
         kind_ff     <= kind_in;
         irq_kind_ff <= irq_kind_in;
      end
   end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import gpp_pkg::*;

   localparam int PIN_COUNT   = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SHOW_LIMIT  = 10;

   typedef struct {
      logic [31:0] read_data;
      logic        error;
      logic [31:0] irq_status;
      logic [31:0] pad_levels;
      logic [31:0] pad_direction;
   } gpio_result_type;

   // Shadow copy of the port registers; predicts one result per transaction.
   class gpio_port_scoreboard;
      logic [31:0] out_q, dir_q, en_q, type_q, stat_q, pu_q, pd_q, lvl_q;
      logic [2:0]  kind_q[PIN_COUNT];
      logic [2:0]  irqk_q[PIN_COUNT];
      gpio_result_type pending_results[$];
      int mismatches;

      function new();
         out_q = '0; dir_q = '0; en_q = '0; type_q = '0;
         stat_q = '0; pu_q = '0; pd_q = '0; lvl_q = '0;
         foreach (kind_q[p]) begin
            kind_q[p] = KIND_IN;
            irqk_q[p] = IRQ_NONE;
         end
         mismatches = 0;
      endfunction

      function void drive_pad(int p, logic nl);
         logic ol;
         logic fire;
         ol = lvl_q[p];
         lvl_q[p] = nl;
         fire = 1'b0;
         case (irqk_q[p])
            IRQ_RISE: fire = !ol && nl;
            IRQ_FALL: fire = ol && !nl;
            IRQ_BOTH: fire = ol != nl;
            IRQ_LOW:  fire = !nl;
            IRQ_HIGH: fire = nl;
            default:  fire = 1'b0;
         endcase
         if (fire) stat_q[p] = 1'b1;
      endfunction

      function void drive_word(logic [31:0] v);
         for (int p = 0; p < PIN_COUNT; p++) drive_pad(p, v[p]);
      endfunction

      function void set_kind(int p, logic [2:0] k);
         kind_q[p] = k;
         dir_q[p] = (k == KIND_OUT) || (k == KIND_OD) || (k == KIND_PWM);
      endfunction

      // Pull resolution applies to plain input pins only; pullup wins.
      function logic [31:0] input_word();
         logic [31:0] v;
         v = '0;
         for (int p = 0; p < PIN_COUNT; p++) begin
            v[p] = lvl_q[p];
            if (kind_q[p] == KIND_IN) begin
               if (pu_q[p]) v[p] = 1'b1;
               else if (pd_q[p]) v[p] = 1'b0;
            end
         end
         return v;
      endfunction

      function void predict_access(logic [2:0] m, logic [47:0] d);
         logic [3:0]   ri;
         logic [31:0]  wd;
         logic [5:0]   pn;
         logic         lv;
         logic [2:0]   ps;
         logic [31:0]  rd;
         logic         ok;
         logic         pin_ok;
         gpio_result_type r;
         ri = d[3:0];
         wd = d[35:4];
         pn = d[41:36];
         lv = d[42];
         ps = d[45:43];
         rd = '0;
         ok = 1'b0;
         pin_ok = pn < PIN_COUNT;
         case (m)
            MODE_READ: begin
               ok = 1'b1;
               case (ri)
                  REG_OUT:      rd = out_q;
                  REG_IN:       rd = input_word();
                  REG_DIR:      rd = dir_q;
                  REG_INT_EN:   rd = en_q;
                  REG_INT_TYPE: rd = type_q;
                  REG_INT_STAT: rd = stat_q;
                  REG_PULLUP:   rd = pu_q;
                  REG_PULLDOWN: rd = pd_q;
                  default:      ok = 1'b0;
               endcase
            end
            MODE_WRITE: begin
               ok = 1'b1;
               case (ri)
                  REG_OUT: begin
                     out_q = wd;
                     drive_word(out_q);
                  end
                  REG_SET: begin
                     out_q |= wd;
                     drive_word(out_q);
                  end
                  REG_CLR: begin
                     out_q &= ~wd;
                     drive_word(out_q);
                  end
                  REG_DIR: begin
                     dir_q = wd;
                     for (int p = 0; p < PIN_COUNT; p++) begin
                        if (wd[p]) begin
                           if (kind_q[p] == KIND_IN || kind_q[p] == KIND_IN_PU ||
                               kind_q[p] == KIND_IN_PD)
                              set_kind(p, KIND_OUT);
                        end else if (kind_q[p] == KIND_OUT || kind_q[p] == KIND_OD ||
                                     kind_q[p] == KIND_PWM) begin
                           set_kind(p, KIND_IN);
                        end
                     end
                  end
                  REG_INT_EN: begin
                     en_q = wd;
                     for (int p = 0; p < PIN_COUNT; p++)
                        if (!wd[p]) irqk_q[p] = IRQ_NONE;
                  end
                  REG_INT_TYPE: type_q = wd;
                  REG_INT_CLR:  stat_q &= ~wd;
                  REG_PULLUP:   pu_q = wd;
                  REG_PULLDOWN: pd_q = wd;
                  default:      ok = 1'b0;
               endcase
            end
            MODE_PIN_CHG: begin
               if (pin_ok) begin
                  drive_pad(int'(pn[4:0]), lv);
                  ok = 1'b1;
               end
            end
            MODE_PIN_KIND: begin
               if (pin_ok && ps <= KIND_PWM) begin
                  set_kind(int'(pn[4:0]), ps);
                  ok = 1'b1;
               end
            end
            MODE_PIN_IRQ: begin
               if (pin_ok && ps <= IRQ_HIGH) begin
                  irqk_q[pn[4:0]] = ps;
                  en_q[pn[4:0]] = ps != IRQ_NONE;
                  ok = 1'b1;
               end
            end
            default: ok = 1'b0;
         endcase
         r.read_data     = rd;
         r.error         = !ok;
         r.irq_status    = stat_q;
         r.pad_levels    = lvl_q;
         r.pad_direction = dir_q;
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void flag(string field, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= SHOW_LIMIT)
            $display("mismatch %0s: expected %08h, got %08h", field, want, got);
      endfunction

      function void check_result(logic [135:0] t);
         gpio_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
               $display("unexpected rsp transaction: %034h", t);
         end else begin
            want = pending_results.pop_front();
            if (t[31:0] !== want.read_data)      flag("read_data", want.read_data, t[31:0]);
            if (t[32] !== want.error)
               flag("error", 32'(want.error), 32'(t[32]));
            if (t[64:33] !== want.irq_status)    flag("irq_status", want.irq_status, t[64:33]);
            if (t[96:65] !== want.pad_levels)    flag("pad_levels", want.pad_levels, t[96:65]);
            if (t[128:97] !== want.pad_direction)
               flag("pad_direction", want.pad_direction, t[128:97]);
         end
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [2:0]   req_tuser;
   logic [47:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;

   gpio_port_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;
   int cycles;

   gpio_port_with_pin_interrupts_unit #(.PIN_COUNT(PIN_COUNT)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [47:0] req_word(logic [3:0] ri, logic [31:0] wd, logic [5:0] pn,
                                            logic lv, logic [2:0] ps);
      return {2'b00, ps, lv, pn, wd, ri};
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         2:       return 32'd1 << $urandom_range(31);
         3:       return ~(32'd1 << $urandom_range(31));
         default: return $urandom;
      endcase
   endfunction

   // Mostly valid pins, some beyond the port to hit the error path.
   function automatic logic [5:0] rand_pin();
      if ($urandom_range(9) == 0) return 6'($urandom_range(63, 32));
      return 6'($urandom_range(PIN_COUNT - 1));
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic push_item(input logic [2:0] m, input logic [47:0] d);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser  = m;
      req_tdata  = d;
      req_tvalid = 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_tready;
         @(negedge clock);
      end
      sb.predict_access(m, d);
      items_sent++;
   endtask

   task automatic run_random(input int count);
      int          target;
      int          sel;
      int          n;
      logic [5:0]  pn;
      logic [3:0]  ri;
      target = items_sent + count;
      while (items_sent < target) begin
         sel = $urandom_range(99);
         pn = rand_pin();
         if (sel < 8) begin
            // noise: any kind, any fields
            push_item(3'($urandom_range(7)),
                      {2'b00, 16'($urandom_range(16'hffff, 0)), 30'($urandom)});
         end else if (sel < 45) begin
            // arm an interrupt, wiggle the pin, read status and sometimes clear it
            if ($urandom_range(3) == 0)
               push_item(MODE_PIN_KIND, req_word('0, '0, pn, 1'b0, 3'($urandom_range(7))));
            push_item(MODE_PIN_IRQ, req_word('0, '0, pn, 1'b0,
                      3'(($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(5))));
            n = $urandom_range(1, 5);
            repeat (n)
               push_item(MODE_PIN_CHG, req_word('0, '0, pn, 1'($urandom_range(1)), '0));
            if ($urandom_range(3) == 0)
               push_item(MODE_WRITE, req_word(4'($urandom_range(2)), rand_word(), '0, 1'b0,
                         '0));
            push_item(MODE_READ, req_word(REG_INT_STAT, '0, '0, 1'b0, '0));
            if ($urandom_range(1))
               push_item(MODE_WRITE, req_word(REG_INT_CLR,
                         $urandom_range(1) ? (32'd1 << pn[4:0]) : rand_word(), '0, 1'b0, '0));
         end else if (sel < 60) begin
            // pull resolution against pin modes and levels
            push_item(MODE_WRITE, req_word(REG_PULLUP, rand_word(), '0, 1'b0, '0));
            push_item(MODE_WRITE, req_word(REG_PULLDOWN, rand_word(), '0, 1'b0, '0));
            push_item(MODE_PIN_KIND, req_word('0, '0, pn, 1'b0, 3'($urandom_range(6))));
            push_item(MODE_PIN_CHG, req_word('0, '0, rand_pin(), 1'($urandom_range(1)), '0));
            push_item(MODE_READ, req_word(REG_IN, '0, '0, 1'b0, '0));
         end else begin
            ri = 4'(($urandom_range(7) == 0) ? $urandom_range(15, 11) : $urandom_range(10));
            push_item(3'($urandom_range(4)), req_word(ri, rand_word(), pn,
                      1'($urandom_range(1)), 3'($urandom_range(7))));
         end
      end
   endtask

   // result side: random stall decided at each falling edge
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = $urandom_range(99) >= recv_idle_pct;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      items_sent = 0;
      send_idle_pct = 26;
      recv_idle_pct = 84;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      push_item(MODE_READ,     req_word(REG_OUT, '0, '0, 1'b0, '0));
      push_item(MODE_WRITE,    req_word(REG_OUT, 32'hffff_ffff, '0, 1'b0, '0));
      push_item(MODE_WRITE,    req_word(REG_CLR, 32'hffff_0000, '0, 1'b0, '0));
      push_item(MODE_WRITE,    req_word(REG_SET, 32'h8000_0001, '0, 1'b0, '0));
      push_item(MODE_WRITE,    req_word(REG_DIR, 32'haaaa_5555, '0, 1'b0, '0));
      push_item(MODE_PIN_KIND, req_word('0, '0, 6'd0, 1'b0, KIND_ANALOG));
      push_item(MODE_PIN_KIND, req_word('0, '0, 6'd31, 1'b0, KIND_OD));
      push_item(MODE_PIN_KIND, req_word('0, '0, 6'd3, 1'b0, 3'd7));     // bad pin mode
      push_item(MODE_PIN_IRQ,  req_word('0, '0, 6'd0, 1'b0, IRQ_BOTH));
      push_item(MODE_PIN_IRQ,  req_word('0, '0, 6'd31, 1'b0, IRQ_LOW));
      push_item(MODE_PIN_IRQ,  req_word('0, '0, 6'd2, 1'b0, 3'd6));     // bad irq mode
      push_item(MODE_PIN_IRQ,  req_word('0, '0, 6'd40, 1'b0, IRQ_RISE)); // pin out of range
      push_item(MODE_PIN_CHG,  req_word('0, '0, 6'd0, 1'b0, '0));
      push_item(MODE_PIN_CHG,  req_word('0, '0, 6'd31, 1'b0, '0));
      push_item(MODE_PIN_CHG,  req_word('0, '0, 6'd63, 1'b1, '0));
      push_item(MODE_READ,     req_word(REG_INT_STAT, '0, '0, 1'b0, '0));
      push_item(MODE_WRITE,    req_word(REG_INT_STAT, 32'hffff_ffff, '0, 1'b0, '0));
      push_item(MODE_WRITE,    req_word(REG_INT_CLR, 32'hffff_ffff, '0, 1'b0, '0));
      push_item(MODE_WRITE,    req_word(REG_PULLUP, 32'h0000_ffff, '0, 1'b0, '0));
      push_item(MODE_WRITE,    req_word(REG_PULLDOWN, 32'hffff_ff00, '0, 1'b0, '0));
      push_item(MODE_READ,     req_word(REG_IN, '0, '0, 1'b0, '0));
      push_item(MODE_WRITE,    req_word(REG_INT_TYPE, 32'hffff_ffff, '0, 1'b0, '0));
      push_item(MODE_WRITE,    req_word(REG_INT_EN, 32'h0, '0, 1'b0, '0));
      push_item(MODE_READ,     req_word(REG_INT_CLR, '0, '0, 1'b0, '0));
      push_item(MODE_WRITE,    req_word(4'd15, 32'h1234_5678, '0, 1'b0, '0));
      push_item(3'd7,          req_word(REG_OUT, 32'hffff_ffff, 6'd1, 1'b1, 3'd7));

      run_random(270);
      send_idle_pct = 84;
      recv_idle_pct = 26;
      run_random(270);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(270);
      req_tvalid = 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/gpp_pkg.sv
src/gpp_pin.sv
src/gpio_port_with_pin_interrupts_unit.sv
sim/tb_top.sv
